### design/assert_macros.svh
// Assertion macros shared by the blitter RTL files.
// No dependencies; every user includes it by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BLT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/blt_pkg.sv
// Shared types and constants of the rectangle fill and palette blitter.
// No dependencies; used by every module of the block but blt_ram.
package blt_pkg;

    localparam int DEF_MAX_COLUMNS   = 1024;
    localparam int DEF_MAX_ROWS      = 1024;
    localparam int DEF_PALETTE_DEPTH = 256;

    localparam int ORG_W   = 10;
    localparam int DIM_W   = 11;
    localparam int VALUE_W = 32;
    localparam int COLOR_W = 24;
    localparam int INDEX_W = 8;
    localparam int ADDR_W  = 20;
    localparam int CFG_IDX_W = 1;

    localparam logic [DIM_W-1:0] RESET_BUFFER_WIDTH  = 11'd320;
    localparam logic [DIM_W-1:0] RESET_BUFFER_HEIGHT = 11'd240;

    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        OP_PALETTE_WRITE = 2'd0,
        OP_START_FILL    = 2'd1,
        OP_START_PICTURE = 2'd2,
        OP_ADVANCE       = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'b001,
        MODE_FILL    = 3'b010,
        MODE_PICTURE = 3'b100
    } t_mode;

    // Source of the pixel word chosen in the output stage.
    typedef enum logic [1:0] {
        VSEL_FILL    = 2'd0,
        VSEL_RAW     = 2'd1,
        VSEL_PALETTE = 2'd2,
        VSEL_ZERO    = 2'd3
    } t_vsel;

    typedef struct packed {
        logic  valid;
        logic  last;
        t_vsel vsel;
    } t_pix_ctl;

endpackage

### design/blt_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module blt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/blt_raster.sv
// Rectangle sequencer: start commands, clipping and raster stepping.
// Depends on blt_pkg and assert_macros.svh; feeds the output stage.
`include "assert_macros.svh"

module blt_raster #(
    parameter int MAX_COLUMNS   = blt_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS      = blt_pkg::DEF_MAX_ROWS,
    parameter int PALETTE_DEPTH = blt_pkg::DEF_PALETTE_DEPTH,
    localparam int CCNT_W    = $clog2(MAX_COLUMNS + 1),
    localparam int RCNT_W    = $clog2(MAX_ROWS + 1),
    localparam int COL_POS_W =
        ((blt_pkg::ORG_W > CCNT_W) ? blt_pkg::ORG_W : CCNT_W) + 1,
    localparam int ROW_POS_W =
        ((blt_pkg::ORG_W > RCNT_W) ? blt_pkg::ORG_W : RCNT_W) + 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_accept,
    input  blt_pkg::t_op                   i_operation,
    input  logic [blt_pkg::ORG_W-1:0]      i_origin_x,
    input  logic [blt_pkg::ORG_W-1:0]      i_origin_y,
    input  logic [blt_pkg::DIM_W-1:0]      i_rect_width,
    input  logic [blt_pkg::DIM_W-1:0]      i_rect_height,
    input  logic [blt_pkg::VALUE_W-1:0]    i_fill_value,
    input  logic                           i_expand_palette,
    input  logic [blt_pkg::INDEX_W-1:0]    i_source_index,
    input  logic [blt_pkg::DIM_W-1:0]      i_buffer_width,
    input  logic [blt_pkg::DIM_W-1:0]      i_buffer_height,
    output blt_pkg::t_pix_ctl              o_ctl,
    output logic [ROW_POS_W-1:0]           o_row,
    output logic [COL_POS_W-1:0]           o_col,
    output logic [blt_pkg::INDEX_W-1:0]    o_index,
    output logic [blt_pkg::VALUE_W-1:0]    o_fill
);

    localparam int CCLIP_W = ((blt_pkg::DIM_W > CCNT_W) ? blt_pkg::DIM_W : CCNT_W) + 1;
    localparam int RCLIP_W = ((blt_pkg::DIM_W > RCNT_W) ? blt_pkg::DIM_W : RCNT_W) + 1;

    blt_pkg::t_mode              r_mode, n_mode;
    logic                        r_use_pal, n_use_pal;
    logic [blt_pkg::ORG_W-1:0]   r_start_col, n_start_col;
    logic [blt_pkg::ORG_W-1:0]   r_start_row, n_start_row;
    logic [CCNT_W-1:0]           r_active_w, n_active_w;
    logic [RCNT_W-1:0]           r_active_h, n_active_h;
    logic [CCNT_W-1:0]           r_col_off, n_col_off;
    logic [RCNT_W-1:0]           r_row_off, n_row_off;
    logic [blt_pkg::VALUE_W-1:0] r_held_fill, n_held_fill;

    blt_pkg::t_pix_ctl           r_s1_ctl, n_s1_ctl;
    logic [ROW_POS_W-1:0]        r_s1_row;
    logic [COL_POS_W-1:0]        r_s1_col;
    logic [blt_pkg::INDEX_W-1:0] r_s1_index;

    logic [CCNT_W-1:0]    rw_sat, rw_clip;
    logic [RCNT_W-1:0]    rh_sat, rh_clip;
    logic                 off_screen;
    logic [COL_POS_W-1:0] col_now;
    logic [ROW_POS_W-1:0] row_now;
    logic [CCNT_W-1:0]    col_step;
    logic [RCNT_W-1:0]    row_step;
    logic                 visible;
    logic                 last_now;
    logic                 adv_live;
    blt_pkg::t_vsel       vsel_now;

    // Size saturation and clipping against the buffer edge.
    always_comb begin
        rw_sat = (int'(i_rect_width) > MAX_COLUMNS) ? CCNT_W'(MAX_COLUMNS)
                                                    : CCNT_W'(i_rect_width);
        rh_sat = (int'(i_rect_height) > MAX_ROWS) ? RCNT_W'(MAX_ROWS)
                                                  : RCNT_W'(i_rect_height);
        off_screen = (blt_pkg::DIM_W'(i_origin_x) >= i_buffer_width) ||
                     (blt_pkg::DIM_W'(i_origin_y) >= i_buffer_height);
        rw_clip = rw_sat;
        if ((CCLIP_W'(i_origin_x) + CCLIP_W'(rw_sat)) > CCLIP_W'(i_buffer_width)) begin
            rw_clip = CCNT_W'(i_buffer_width - blt_pkg::DIM_W'(i_origin_x));
        end
        rh_clip = rh_sat;
        if ((RCLIP_W'(i_origin_y) + RCLIP_W'(rh_sat)) > RCLIP_W'(i_buffer_height)) begin
            rh_clip = RCNT_W'(i_buffer_height - blt_pkg::DIM_W'(i_origin_y));
        end
    end

    // Current raster position and what this advance would emit.
    always_comb begin
        col_now  = COL_POS_W'(r_start_col) + COL_POS_W'(r_col_off);
        row_now  = ROW_POS_W'(r_start_row) + ROW_POS_W'(r_row_off);
        col_step = r_col_off + CCNT_W'(1);
        row_step = r_row_off + RCNT_W'(1);
        last_now = (col_step == r_active_w) && (row_step == r_active_h);
        visible  = (r_mode == blt_pkg::MODE_FILL) ||
                   ((col_now < COL_POS_W'(i_buffer_width)) &&
                    (row_now < ROW_POS_W'(i_buffer_height)));
        if (r_mode == blt_pkg::MODE_FILL) begin
            vsel_now = blt_pkg::VSEL_FILL;
        end else if (!r_use_pal) begin
            vsel_now = blt_pkg::VSEL_RAW;
        end else if (int'(i_source_index) < PALETTE_DEPTH) begin
            vsel_now = blt_pkg::VSEL_PALETTE;
        end else begin
            vsel_now = blt_pkg::VSEL_ZERO;
        end
        adv_live = i_accept && (i_operation == blt_pkg::OP_ADVANCE) &&
                   (r_mode != blt_pkg::MODE_IDLE);
    end

    always_comb begin
        n_mode      = r_mode;
        n_use_pal   = r_use_pal;
        n_start_col = r_start_col;
        n_start_row = r_start_row;
        n_active_w  = r_active_w;
        n_active_h  = r_active_h;
        n_col_off   = r_col_off;
        n_row_off   = r_row_off;
        n_held_fill = r_held_fill;
        if (i_accept) begin
            case (i_operation)
                blt_pkg::OP_START_FILL: begin
                    n_held_fill = i_fill_value;
                    if (off_screen) begin
                        n_mode = blt_pkg::MODE_IDLE;
                    end else begin
                        n_start_col = i_origin_x;
                        n_start_row = i_origin_y;
                        n_active_w  = rw_clip;
                        n_active_h  = rh_clip;
                        n_col_off   = '0;
                        n_row_off   = '0;
                        n_mode = ((rw_clip == '0) || (rh_clip == '0)) ? blt_pkg::MODE_IDLE
                                                                      : blt_pkg::MODE_FILL;
                    end
                end
                blt_pkg::OP_START_PICTURE: begin
                    n_use_pal   = i_expand_palette;
                    n_start_col = i_origin_x;
                    n_start_row = i_origin_y;
                    n_active_w  = rw_sat;
                    n_active_h  = rh_sat;
                    n_col_off   = '0;
                    n_row_off   = '0;
                    n_mode = ((rw_sat == '0) || (rh_sat == '0)) ? blt_pkg::MODE_IDLE
                                                                : blt_pkg::MODE_PICTURE;
                end
                blt_pkg::OP_ADVANCE: begin
                    if (r_mode != blt_pkg::MODE_IDLE) begin
                        if (col_step == r_active_w) begin
                            n_col_off = '0;
                            if (row_step == r_active_h) begin
                                n_row_off = '0;
                                n_mode    = blt_pkg::MODE_IDLE;
                            end else begin
                                n_row_off = row_step;
                            end
                        end else begin
                            n_col_off = col_step;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_s1_ctl.valid = adv_live && visible;
        n_s1_ctl.last  = last_now;
        n_s1_ctl.vsel  = vsel_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= blt_pkg::MODE_IDLE;
            r_use_pal   <= 1'b0;
            r_start_col <= '0;
            r_start_row <= '0;
            r_active_w  <= '0;
            r_active_h  <= '0;
            r_col_off   <= '0;
            r_row_off   <= '0;
            r_held_fill <= '0;
            r_s1_ctl    <= '{valid: 1'b0, last: 1'b0, vsel: blt_pkg::VSEL_FILL};
        end else begin
            r_mode      <= n_mode;
            r_use_pal   <= n_use_pal;
            r_start_col <= n_start_col;
            r_start_row <= n_start_row;
            r_active_w  <= n_active_w;
            r_active_h  <= n_active_h;
            r_col_off   <= n_col_off;
            r_row_off   <= n_row_off;
            r_held_fill <= n_held_fill;
            if (i_en) begin
                r_s1_ctl <= n_s1_ctl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_row   <= row_now;
            r_s1_col   <= col_now;
            r_s1_index <= i_source_index;
        end
    end

    assign o_ctl   = r_s1_ctl;
    assign o_row   = r_s1_row;
    assign o_col   = r_s1_col;
    assign o_index = r_s1_index;
    assign o_fill  = r_held_fill;

    `BLT_ASSERT_IMPL(a_offsets_in_rect, i_clk, i_rst_n,
        r_mode != blt_pkg::MODE_IDLE,
        (r_col_off < r_active_w) && (r_row_off < r_active_h),
        "raster offset outside the active rectangle")
    `BLT_ASSERT_IMPL(a_last_closes_rect, i_clk, i_rst_n,
        r_s1_ctl.valid && r_s1_ctl.last,
        r_mode == blt_pkg::MODE_IDLE,
        "final pixel in flight while a rectangle is still open")

endmodule

### design/blt_emit.sv
// Output stage: address multiply-add, pixel word select and result register.
// Depends on blt_pkg and assert_macros.svh; reads the palette RAM data.
`include "assert_macros.svh"

module blt_emit #(
    parameter int ROW_POS_W = 11,
    parameter int COL_POS_W = 11
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  blt_pkg::t_pix_ctl           i_ctl,
    input  logic [ROW_POS_W-1:0]        i_row,
    input  logic [COL_POS_W-1:0]        i_col,
    input  logic [blt_pkg::INDEX_W-1:0] i_index,
    input  logic [blt_pkg::VALUE_W-1:0] i_fill,
    input  logic [blt_pkg::COLOR_W-1:0] i_pal,
    input  logic [blt_pkg::DIM_W-1:0]   i_buffer_width,
    output logic                        o_valid,
    output logic [blt_pkg::ADDR_W-1:0]  o_addr,
    output logic [blt_pkg::VALUE_W-1:0] o_value,
    output logic                        o_last
);

    localparam int PROD_W = ROW_POS_W + blt_pkg::DIM_W;
    localparam int SUM_W  = ((PROD_W > COL_POS_W) ? PROD_W : COL_POS_W) + 1;

    logic                        r_valid;
    logic [blt_pkg::ADDR_W-1:0]  r_addr;
    logic [blt_pkg::VALUE_W-1:0] r_value;
    logic                        r_last;

    logic [PROD_W-1:0]           prod;
    logic [SUM_W-1:0]            sum;
    logic [blt_pkg::VALUE_W-1:0] value;

    always_comb begin
        prod = PROD_W'(i_row) * PROD_W'(i_buffer_width);
        sum  = SUM_W'(prod) + SUM_W'(i_col);
        case (i_ctl.vsel)
            blt_pkg::VSEL_FILL:    value = i_fill;
            blt_pkg::VSEL_RAW:     value = blt_pkg::VALUE_W'(i_index);
            blt_pkg::VSEL_PALETTE: value = blt_pkg::VALUE_W'(i_pal);
            default:               value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_addr  <= sum[blt_pkg::ADDR_W-1:0];
            r_value <= value;
            r_last  <= i_ctl.last;
        end
    end

    assign o_valid = r_valid;
    assign o_addr  = r_addr;
    assign o_value = r_value;
    assign o_last  = r_last;

    `BLT_ASSERT_NEXT(a_pixel_reaches_output, i_clk, i_rst_n,
        i_en && i_ctl.valid,
        r_valid,
        "pending pixel lost on its way to the output register")

endmodule

### design/rect_fill_and_palette_blitter_core.sv
// Top level of the rectangle fill and palette blitter.
// Depends on blt_pkg, blt_ram, blt_raster, blt_emit and assert_macros.svh.
//
//   Channel   Direction  Handshake                    Beat contents
//   input     in         i_in_valid / o_in_stall      operation and its operands
//   output    out        o_out_valid / i_out_stall    pixel address, value, last flag
//   config    in         i_cfg_valid / o_cfg_ready    register index and data
//
// Every input beat takes one cycle; a new beat may be taken on each clock.
// An advance beat is registered in the raster stage, with the palette RAM read,
// and then in the output register after the row times width multiply-add.
// Reset idles the sequencer, empties the pipe and restores the 320 by 240
// buffer; the palette RAM is not cleared. A stalled output beat freezes the
// pipe, so o_in_stall follows i_out_stall only while a result is waiting.
`include "assert_macros.svh"

module rect_fill_and_palette_blitter_core #(
    parameter int MAX_COLUMNS   = blt_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS      = blt_pkg::DEF_MAX_ROWS,
    parameter int PALETTE_DEPTH = blt_pkg::DEF_PALETTE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_operation,
    input  logic [blt_pkg::ORG_W-1:0]     i_origin_x,
    input  logic [blt_pkg::ORG_W-1:0]     i_origin_y,
    input  logic [blt_pkg::DIM_W-1:0]     i_rect_width,
    input  logic [blt_pkg::DIM_W-1:0]     i_rect_height,
    input  logic [blt_pkg::VALUE_W-1:0]   i_fill_value,
    input  logic                          i_expand_palette,
    input  logic [blt_pkg::INDEX_W-1:0]   i_source_index,
    input  logic [blt_pkg::INDEX_W-1:0]   i_palette_slot,
    input  logic [blt_pkg::COLOR_W-1:0]   i_palette_color,
    // Output channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [blt_pkg::ADDR_W-1:0]    o_pixel_address,
    output logic [blt_pkg::VALUE_W-1:0]   o_pixel_value,
    output logic                          o_last_pixel,
    // Configuration channel.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [blt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [blt_pkg::DIM_W-1:0]     i_cfg_data
);

    localparam int CCNT_W    = $clog2(MAX_COLUMNS + 1);
    localparam int RCNT_W    = $clog2(MAX_ROWS + 1);
    localparam int COL_POS_W =
        ((blt_pkg::ORG_W > CCNT_W) ? blt_pkg::ORG_W : CCNT_W) + 1;
    localparam int ROW_POS_W =
        ((blt_pkg::ORG_W > RCNT_W) ? blt_pkg::ORG_W : RCNT_W) + 1;
    localparam int PAL_AW    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    logic [blt_pkg::DIM_W-1:0] r_buffer_width;
    logic [blt_pkg::DIM_W-1:0] r_buffer_height;

    blt_pkg::t_op              op;
    logic                      en;
    logic                      accept;
    logic                      pal_we;
    logic                      pal_re;
    logic [blt_pkg::COLOR_W-1:0] pal_rdata;

    blt_pkg::t_pix_ctl           s1_ctl;
    logic [ROW_POS_W-1:0]        s1_row;
    logic [COL_POS_W-1:0]        s1_col;
    logic [blt_pkg::INDEX_W-1:0] s1_index;
    logic [blt_pkg::VALUE_W-1:0] held_fill;
    logic                        out_valid;

    // The pipe moves whenever the output register is empty or being drained.
    assign op         = blt_pkg::t_op'(i_operation);
    assign en         = !(out_valid && i_out_stall);
    assign accept     = i_in_valid && en;
    assign o_in_stall = !en;
    assign o_cfg_ready = 1'b1;

    // Slots at or above the palette depth are silently ignored on write.
    assign pal_we = accept && (op == blt_pkg::OP_PALETTE_WRITE) &&
                    (int'(i_palette_slot) < PALETTE_DEPTH);
    assign pal_re = accept && (op == blt_pkg::OP_ADVANCE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_width  <= blt_pkg::RESET_BUFFER_WIDTH;
            r_buffer_height <= blt_pkg::RESET_BUFFER_HEIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                blt_pkg::CFG_BUFFER_WIDTH:  r_buffer_width  <= i_cfg_data;
                blt_pkg::CFG_BUFFER_HEIGHT: r_buffer_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Palette memory; an entry is read on every advance beat and used only
    // when the open picture maps indices through the palette.
    blt_ram #(
        .WIDTH (blt_pkg::COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (i_palette_slot[PAL_AW-1:0]),
        .i_wdata (i_palette_color),
        .i_re    (pal_re),
        .i_raddr (i_source_index[PAL_AW-1:0]),
        .o_rdata (pal_rdata)
    );

    blt_raster #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .MAX_ROWS      (MAX_ROWS),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_raster (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_accept         (accept),
        .i_operation      (op),
        .i_origin_x       (i_origin_x),
        .i_origin_y       (i_origin_y),
        .i_rect_width     (i_rect_width),
        .i_rect_height    (i_rect_height),
        .i_fill_value     (i_fill_value),
        .i_expand_palette (i_expand_palette),
        .i_source_index   (i_source_index),
        .i_buffer_width   (r_buffer_width),
        .i_buffer_height  (r_buffer_height),
        .o_ctl            (s1_ctl),
        .o_row            (s1_row),
        .o_col            (s1_col),
        .o_index          (s1_index),
        .o_fill           (held_fill)
    );

    blt_emit #(
        .ROW_POS_W (ROW_POS_W),
        .COL_POS_W (COL_POS_W)
    ) u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_ctl          (s1_ctl),
        .i_row          (s1_row),
        .i_col          (s1_col),
        .i_index        (s1_index),
        .i_fill         (held_fill),
        .i_pal          (pal_rdata),
        .i_buffer_width (r_buffer_width),
        .o_valid        (out_valid),
        .o_addr         (o_pixel_address),
        .o_value        (o_pixel_value),
        .o_last         (o_last_pixel)
    );

    assign o_out_valid = out_valid;

    `BLT_ASSERT_IMPL(a_stall_needs_result, i_clk, i_rst_n,
        o_in_stall,
        o_out_valid && i_out_stall,
        "input stalled without a waiting result")
    `BLT_ASSERT_IMPL(a_palette_port_exclusive, i_clk, i_rst_n,
        pal_we,
        !pal_re,
        "palette written and read by the same beat")

endmodule
